// ===== design/pta_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pta_pkg: shared types and constants of the pixel tone adjust unit
// Pixel type, register map, luma weights, temperature factors and the widths
// of the fixed-point datapath.
// ----------------------------------------------------------------------------
package pta_pkg;

  // pixel channel
  localparam int PIX_W = 8;
  typedef logic [PIX_W-1:0] pix_t;

  // configuration register widths
  localparam int EXP_W  = 16;
  localparam int GAIN_W = 14;
  localparam int TEMP_W = 10;

  // apb port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // register map, byte address 4 * index
  typedef enum logic [1:0] {
    REG_EXPOSURE    = 2'd0,
    REG_CONTRAST    = 2'd1,
    REG_SATURATION  = 2'd2,
    REG_TEMPERATURE = 2'd3
  } cfg_reg_t;

  // reset values
  localparam logic [EXP_W-1:0]         EXP_RST  = 16'd4096;
  localparam logic [GAIN_W-1:0]        GAIN_RST = 14'd4096;
  localparam logic signed [TEMP_W-1:0] TEMP_RST = 10'sd0;

  // pipeline depth
  localparam int NSTG = 7;

  // datapath widths
  localparam int PROD_W = PIX_W + EXP_W;    // channel times exposure gain
  localparam int TADD_W = 20;               // temperature term, q.12
  localparam int X_W    = 26;               // channel minus mid gray, q.12
  localparam int LW_W   = 17;               // signed luma weight
  localparam int WX_W   = 43;               // weighted sum and luma difference
  localparam int YL_W   = 22;               // low part of luma difference
  localparam int PL_W   = 36;               // saturation partial products
  localparam int Z_W    = 58;               // blended value before contrast
  localparam int ZL_W   = 29;               // low part of blended value
  localparam int QL_W   = 43;               // contrast partial product, low
  localparam int QH_W   = 44;               // contrast partial product, high
  localparam int P_W    = 73;               // full product, q.52
  localparam int FLOOR_SH = 52;
  localparam int F_W    = P_W - FLOOR_SH;   // floored value
  localparam int SUM_SH = 12;               // luma term scale in the blend
  localparam int DIFF_SH = 16;              // channel scale against luma

  // mid gray in q.12 and output offset
  localparam logic signed [X_W-1:0] MID12   = 26'sd524288;
  localparam logic signed [F_W:0]   MID_OUT = 22'sd128;
  localparam logic signed [F_W:0]   PIX_MAX = 22'sd255;

  // luma weights in q0.16, red, green, blue
  localparam logic signed [LW_W-1:0] LUMA_W [3] = '{17'sd19595, 17'sd38470, 17'sd7471};

  // temperature factors in q.12 per unit of 1/256
  localparam logic signed [TADD_W-1:0] WARM_RED  = 20'sd480;
  localparam logic signed [TADD_W-1:0] WARM_BLUE = -20'sd480;
  localparam logic signed [TADD_W-1:0] COOL_RED  = 20'sd320;
  localparam logic signed [TADD_W-1:0] COOL_BLUE = -20'sd560;

endpackage

// ===== design/pta_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pta_in_if: input pixel channel
// Valid/ready handshake carrying one argb pixel per request.
// ----------------------------------------------------------------------------
interface pta_in_if;
  logic         valid;
  logic         ready;
  pta_pkg::pix_t red_in;
  pta_pkg::pix_t green_in;
  pta_pkg::pix_t blue_in;
  pta_pkg::pix_t alpha_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  output alpha_in, input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in,
                  input alpha_in, output ready);
endinterface

// ===== design/pta_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pta_out_if: adjusted pixel channel
// Valid/ready handshake carrying one adjusted argb pixel per request.
// ----------------------------------------------------------------------------
interface pta_out_if;
  logic         valid;
  logic         ready;
  pta_pkg::pix_t red_out;
  pta_pkg::pix_t green_out;
  pta_pkg::pix_t blue_out;
  pta_pkg::pix_t alpha_out;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output alpha_out, input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  input alpha_out, output ready);
endinterface

// ===== design/pixel_tone_adjust_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_tone_adjust_unit: exposure, temperature, contrast and saturation
// Per-pixel tone adjustment of an argb stream with apb-style configuration.
// ----------------------------------------------------------------------------
// Takes one pixel per clock unless the pipeline stalls and returns it adjusted. The
// datapath is a seven-stage pipeline: exposure and temperature, luma weights,
// luma sum and differences, two saturation partial products, blend, two
// contrast partial products, and a final 73-bit sum with floor and clamp into
// the output register. Every stage carries its own valid bit and loads when
// it is empty or the stage after it moves, so bubbles close up and a new
// request is taken while a finished pixel waits on the output. The registers
// (exposure gain, contrast gain, saturation gain, color temperature at byte
// addresses 0, 4, 8 and 12) are meant to be written while no pixel is in
// flight. Exact arithmetic: no rounding anywhere before the final floor.
// ----------------------------------------------------------------------------
module pixel_tone_adjust_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  pta_in_if.sink                       in_pix,
  pta_out_if.source                    out_pix,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [pta_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [pta_pkg::DATA_W-1:0]   cfg_pwdata,
  output logic [pta_pkg::DATA_W-1:0]   cfg_prdata,
  output logic                         cfg_pready
);

  // configuration registers
  logic [pta_pkg::EXP_W-1:0]          exp_gain_r;
  logic [pta_pkg::GAIN_W-1:0]         con_gain_r;
  logic [pta_pkg::GAIN_W-1:0]         sat_gain_r;
  logic signed [pta_pkg::TEMP_W-1:0]  temp_r;
  logic                               cfg_wr;
  pta_pkg::cfg_reg_t                  cfg_idx;

  // pipeline control
  logic [pta_pkg::NSTG-1:0] vld_r;
  logic [pta_pkg::NSTG-1:0] vld_nxt;
  logic [pta_pkg::NSTG-1:0] rdy;
  pta_pkg::pix_t            alpha_r [pta_pkg::NSTG];

  // stage data
  pta_pkg::pix_t                       ch_in [3];
  logic [pta_pkg::PROD_W-1:0]          exp_prod [3];
  logic signed [pta_pkg::TADD_W-1:0]   tadd [3];
  logic signed [pta_pkg::TADD_W-1:0]   temp_ext;
  logic signed [pta_pkg::X_W-1:0]      s1_x_nxt [3];
  logic signed [pta_pkg::X_W-1:0]      s1_x_r [3];
  logic signed [pta_pkg::WX_W-1:0]     s2_wx_nxt [3];
  logic signed [pta_pkg::WX_W-1:0]     s2_wx_r [3];
  logic signed [pta_pkg::X_W-1:0]      s2_x_r [3];
  logic signed [pta_pkg::WX_W-1:0]     s3_sum_nxt;
  logic signed [pta_pkg::WX_W-1:0]     s3_sum_r;
  logic signed [pta_pkg::WX_W-1:0]     s3_y_nxt [3];
  logic signed [pta_pkg::WX_W-1:0]     s3_y_r [3];
  logic [pta_pkg::PL_W-1:0]            s4_pl_nxt [3];
  logic [pta_pkg::PL_W-1:0]            s4_pl_r [3];
  logic signed [pta_pkg::PL_W-1:0]     s4_ph_nxt [3];
  logic signed [pta_pkg::PL_W-1:0]     s4_ph_r [3];
  logic signed [pta_pkg::WX_W-1:0]     s4_sum_r;
  logic signed [pta_pkg::Z_W-1:0]      s5_z_nxt [3];
  logic signed [pta_pkg::Z_W-1:0]      s5_z_r [3];
  logic [pta_pkg::QL_W-1:0]            s6_ql_nxt [3];
  logic [pta_pkg::QL_W-1:0]            s6_ql_r [3];
  logic signed [pta_pkg::QH_W-1:0]     s6_qh_nxt [3];
  logic signed [pta_pkg::QH_W-1:0]     s6_qh_r [3];
  pta_pkg::pix_t                       s7_pix_nxt [3];
  pta_pkg::pix_t                       s7_pix_r [3];

  // --------------------------------------------------------------------------
  // configuration port
  // --------------------------------------------------------------------------

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = pta_pkg::cfg_reg_t'(cfg_paddr[pta_pkg::ADDR_W-1:2]);

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_gain_r <= pta_pkg::EXP_RST;
      con_gain_r <= pta_pkg::GAIN_RST;
      sat_gain_r <= pta_pkg::GAIN_RST;
      temp_r     <= pta_pkg::TEMP_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        pta_pkg::REG_EXPOSURE:    exp_gain_r <= cfg_pwdata[pta_pkg::EXP_W-1:0];
        pta_pkg::REG_CONTRAST:    con_gain_r <= cfg_pwdata[pta_pkg::GAIN_W-1:0];
        pta_pkg::REG_SATURATION:  sat_gain_r <= cfg_pwdata[pta_pkg::GAIN_W-1:0];
        pta_pkg::REG_TEMPERATURE: temp_r     <= $signed(cfg_pwdata[pta_pkg::TEMP_W-1:0]);
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (cfg_idx)
      pta_pkg::REG_EXPOSURE:    cfg_prdata = pta_pkg::DATA_W'(exp_gain_r);
      pta_pkg::REG_CONTRAST:    cfg_prdata = pta_pkg::DATA_W'(con_gain_r);
      pta_pkg::REG_SATURATION:  cfg_prdata = pta_pkg::DATA_W'(sat_gain_r);
      pta_pkg::REG_TEMPERATURE: cfg_prdata = pta_pkg::DATA_W'(temp_r);
      default:                  cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // pipeline control
  // --------------------------------------------------------------------------

  // a stage loads when it is empty or the next stage loads
  always_comb begin
    rdy[pta_pkg::NSTG-1] = !vld_r[pta_pkg::NSTG-1] || out_pix.ready;
    for (int k = pta_pkg::NSTG - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_pix.ready = rdy[0];

  // valid bits advance with their data
  always_comb begin
    for (int k = 0; k < pta_pkg::NSTG; k++) begin
      if (k == 0) begin
        vld_nxt[k] = rdy[k] ? in_pix.valid : vld_r[k];
      end else begin
        vld_nxt[k] = rdy[k] ? vld_r[k-1] : vld_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // alpha delay line
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      alpha_r[0] <= in_pix.alpha_in;
    end
    for (int k = 1; k < pta_pkg::NSTG; k++) begin
      if (rdy[k]) begin
        alpha_r[k] <= alpha_r[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: exposure gain, temperature shift, offset to mid gray
  // --------------------------------------------------------------------------

  assign ch_in[0] = in_pix.red_in;
  assign ch_in[1] = in_pix.green_in;
  assign ch_in[2] = in_pix.blue_in;

  always_comb begin
    temp_ext = pta_pkg::TADD_W'(temp_r);
    tadd[0]  = '0;
    tadd[1]  = '0;
    tadd[2]  = '0;
    // warm and cool sides use different red and blue factors
    if (temp_r > 0) begin
      tadd[0] = temp_ext * pta_pkg::WARM_RED;
      tadd[2] = temp_ext * pta_pkg::WARM_BLUE;
    end else if (temp_r < 0) begin
      tadd[0] = temp_ext * pta_pkg::COOL_RED;
      tadd[2] = temp_ext * pta_pkg::COOL_BLUE;
    end
    for (int i = 0; i < 3; i++) begin
      exp_prod[i] = pta_pkg::PROD_W'(ch_in[i]) * pta_pkg::PROD_W'(exp_gain_r);
      s1_x_nxt[i] = $signed(pta_pkg::X_W'(exp_prod[i])) + pta_pkg::X_W'(tadd[i])
                    - pta_pkg::MID12;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_x_r <= s1_x_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: luma weights
  // --------------------------------------------------------------------------

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s2_wx_nxt[i] = pta_pkg::WX_W'(s1_x_r[i]) * pta_pkg::WX_W'(pta_pkg::LUMA_W[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s2_wx_r <= s2_wx_nxt;
      s2_x_r  <= s1_x_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: luma sum and channel difference from luma
  // --------------------------------------------------------------------------

  always_comb begin
    s3_sum_nxt = s2_wx_r[0] + s2_wx_r[1] + s2_wx_r[2];
    for (int i = 0; i < 3; i++) begin
      s3_y_nxt[i] = (pta_pkg::WX_W'(s2_x_r[i]) <<< pta_pkg::DIFF_SH) - s3_sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s3_sum_r <= s3_sum_nxt;
      s3_y_r   <= s3_y_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: saturation gain on the difference, two partial products
  // --------------------------------------------------------------------------

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s4_pl_nxt[i] = pta_pkg::PL_W'(sat_gain_r)
                     * pta_pkg::PL_W'(s3_y_r[i][pta_pkg::YL_W-1:0]);
      s4_ph_nxt[i] = $signed(pta_pkg::PL_W'(sat_gain_r))
                     * pta_pkg::PL_W'($signed(s3_y_r[i][pta_pkg::WX_W-1:pta_pkg::YL_W]));
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s4_pl_r  <= s4_pl_nxt;
      s4_ph_r  <= s4_ph_nxt;
      s4_sum_r <= s3_sum_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 5: blend, luma term plus scaled difference
  // --------------------------------------------------------------------------

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s5_z_nxt[i] = (pta_pkg::Z_W'(s4_ph_r[i]) <<< pta_pkg::YL_W)
                    + $signed(pta_pkg::Z_W'(s4_pl_r[i]))
                    + (pta_pkg::Z_W'(s4_sum_r) <<< pta_pkg::SUM_SH);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s5_z_r <= s5_z_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // stage 6: contrast gain, two partial products
  // --------------------------------------------------------------------------

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s6_ql_nxt[i] = pta_pkg::QL_W'(con_gain_r)
                     * pta_pkg::QL_W'(s5_z_r[i][pta_pkg::ZL_W-1:0]);
      s6_qh_nxt[i] = $signed(pta_pkg::QH_W'(con_gain_r))
                     * pta_pkg::QH_W'($signed(s5_z_r[i][pta_pkg::Z_W-1:pta_pkg::ZL_W]));
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      s6_ql_r <= s6_ql_nxt;
      s6_qh_r <= s6_qh_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // stage 7: full product, floor, offset back to mid gray and clamp
  // --------------------------------------------------------------------------

  always_comb begin
    logic signed [pta_pkg::P_W-1:0] prod;
    logic signed [pta_pkg::F_W:0]   val;
    for (int i = 0; i < 3; i++) begin
      prod = (pta_pkg::P_W'(s6_qh_r[i]) <<< pta_pkg::ZL_W)
             + $signed(pta_pkg::P_W'(s6_ql_r[i]));
      val  = pta_pkg::MID_OUT
             + (pta_pkg::F_W + 1)'($signed(prod[pta_pkg::P_W-1:pta_pkg::FLOOR_SH]));
      if (val < 0) begin
        s7_pix_nxt[i] = '0;
      end else if (val > pta_pkg::PIX_MAX) begin
        s7_pix_nxt[i] = '1;
      end else begin
        s7_pix_nxt[i] = val[pta_pkg::PIX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      s7_pix_r <= s7_pix_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // result channel
  // --------------------------------------------------------------------------

  assign out_pix.valid     = vld_r[pta_pkg::NSTG-1];
  assign out_pix.red_out   = s7_pix_r[0];
  assign out_pix.green_out = s7_pix_r[1];
  assign out_pix.blue_out  = s7_pix_r[2];
  assign out_pix.alpha_out = alpha_r[pta_pkg::NSTG-1];

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------

  // an empty output stage lets the whole pipeline move
  a_empty_out_ready : assert property (@(posedge clk) disable iff (!rst_n)
    !out_pix.valid |-> in_pix.ready)
    else $error("input not ready although output stage is empty");

  // an accepted request occupies the first stage
  a_accept_fills : assert property (@(posedge clk) disable iff (!rst_n)
    in_pix.valid && in_pix.ready |=> vld_r[0])
    else $error("accepted request did not reach the first stage");

  // a blocked middle stage keeps its item and data
  a_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[3] && !rdy[3] |=> vld_r[3] && $stable(s4_sum_r))
    else $error("stalled stage lost or changed its item");

endmodule
